[hw/rtl/stm_pkg.sv]
// Shared types and constants for the sorted trimmed mean block.
// Used by every module of the block; depends on nothing.
package stm_pkg;

  localparam int unsigned MaxSamples = 8;
  localparam int unsigned SampleW    = 16;
  localparam int unsigned CntW       = $clog2(MaxSamples + 1);
  localparam int unsigned AddrW      = $clog2(MaxSamples);
  localparam int unsigned HalfW      = CntW - 1;
  localparam int unsigned SumW       = SampleW + AddrW;
  localparam int unsigned StatusW    = 2;
  localparam int unsigned OutDataW   = 24;

  typedef enum logic [StatusW-1:0] {
    STATUS_OK       = 2'd0,
    STATUS_TOO_FEW  = 2'd1,
    STATUS_TOO_MANY = 2'd2
  } status_e;

  // Controller to datapath
  typedef struct packed {
    logic load_in;    // capture the sample, start insertion at the fill level
    logic set_ovf;    // store full: drop the sample
    logic write_val;  // write the sample at the current slot, count it
    logic shift;      // move the entry read below up into the current slot
    logic sum_init;   // start summing at n/4
    logic sum_acc;    // add one entry to the sum
    logic div_start;  // start sum / (n/2)
    logic emit;       // load the output word and end the run
  } stm_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic full;
    logic few;
    logic pos_zero;
    logic pos_one;
    logic less;
    logic last;
    logic sum_done;
    logic div_busy;
    logic out_busy;
  } stm_stat_t;

endpackage

[hw/rtl/stm_div.sv]
// Restoring divider, one quotient bit per cycle.
// Depends on stm_pkg for the sum and divisor widths.
module stm_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [stm_pkg::SumW-1:0]   dividend_i,
  input  logic [stm_pkg::HalfW-1:0]  divisor_i,
  output logic                       busy_o,
  output logic [stm_pkg::SampleW-1:0] quotient_o
);
  import stm_pkg::*;

  localparam int unsigned StepW = $clog2(SumW + 1);

  logic [StepW-1:0] step_q, step_d;
  logic [SumW-1:0]  dvd_q, dvd_d;
  logic [HalfW-1:0] rem_q, rem_d;
  logic [HalfW-1:0] div_q, div_d;
  logic [HalfW:0]   trial;
  logic             fits;

  assign trial = {rem_q, dvd_q[SumW-1]};
  assign fits  = trial >= {1'b0, div_q};

  always_comb begin
    step_d = step_q;
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    div_d  = div_q;
    if (start_i) begin
      step_d = StepW'(SumW);
      dvd_d  = dividend_i;
      rem_d  = '0;
      div_d  = divisor_i;
    end else if (step_q != '0) begin
      step_d = step_q - StepW'(1);
      dvd_d  = {dvd_q[SumW-2:0], fits};
      rem_d  = fits ? HalfW'(trial - {1'b0, div_q}) : trial[HalfW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
    end else begin
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    div_q <= div_d;
  end

  assign busy_o     = step_q != '0;
  assign quotient_o = dvd_q[SampleW-1:0];

endmodule

[hw/rtl/stm_datapath.sv]
// Datapath: sorted sample memory, insertion slot, sum, divider and output word.
// Depends on stm_pkg and stm_div; driven by stm_ctrl commands.
module stm_datapath (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [stm_pkg::SampleW-1:0]  sample_i,
  input  logic                         last_i,
  input  stm_pkg::stm_cmd_t            cmd_i,
  output stm_pkg::stm_stat_t           stat_o,
  input  logic                         out_ready_i,
  output logic                         out_valid_o,
  output logic [stm_pkg::SampleW-1:0]  mean_o,
  output logic [stm_pkg::StatusW-1:0]  status_o
);
  import stm_pkg::*;

  logic [SampleW-1:0] mem [MaxSamples];
  logic [SampleW-1:0] rdata_q;
  logic [AddrW-1:0]   raddr;

  logic [SampleW-1:0] val_q;
  logic               last_q;
  logic [AddrW-1:0]   pos_q, pos_d;
  logic [CntW-1:0]    count_q, count_d;
  logic               ovf_q, ovf_d;
  logic [AddrW-1:0]   idx_q, idx_d;
  logic [HalfW-1:0]   left_q, left_d;
  logic [SumW-1:0]    acc_q, acc_d;
  logic               out_valid_q, out_valid_d;
  logic [SampleW-1:0] mean_q;
  logic [StatusW-1:0] status_q;
  logic               div_busy;
  logic [SampleW-1:0] quotient;
  logic               few;
  logic               we;
  logic [SampleW-1:0] wdata;

  assign few = count_q < CntW'(2);

  always_comb begin
    pos_d   = pos_q;
    count_d = count_q;
    ovf_d   = ovf_q;
    idx_d   = idx_q;
    left_d  = left_q;
    acc_d   = acc_q;
    if (cmd_i.load_in)   pos_d = count_q[AddrW-1:0];
    if (cmd_i.shift)     pos_d = pos_q - AddrW'(1);
    if (cmd_i.write_val) count_d = count_q + CntW'(1);
    if (cmd_i.set_ovf)   ovf_d = 1'b1;
    if (cmd_i.sum_init) begin
      idx_d  = AddrW'(count_q >> 2);
      left_d = count_q[CntW-1:1];
      acc_d  = '0;
    end
    if (cmd_i.sum_acc) begin
      idx_d  = idx_q + AddrW'(1);
      left_d = left_q - HalfW'(1);
      acc_d  = acc_q + SumW'(rdata_q);
    end
    if (cmd_i.emit) begin
      count_d = '0;
      ovf_d   = 1'b0;
    end
  end

  // Read ahead: the entry below the next slot, or the next entry to sum
  assign raddr = (cmd_i.sum_init || cmd_i.sum_acc) ? idx_d : pos_d - AddrW'(1);
  assign we    = cmd_i.write_val || cmd_i.shift;
  assign wdata = cmd_i.shift ? rdata_q : val_q;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[pos_q] <= wdata;
    end
    rdata_q <= mem[raddr];
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_ready_i) out_valid_d = 1'b0;
    if (cmd_i.emit)  out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      ovf_q       <= 1'b0;
      left_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      ovf_q       <= ovf_d;
      left_q      <= left_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q <= pos_d;
    idx_q <= idx_d;
    acc_q <= acc_d;
    if (cmd_i.load_in) begin
      val_q  <= sample_i;
      last_q <= last_i;
    end
    if (cmd_i.emit) begin
      if (few) begin
        mean_q   <= '0;
        status_q <= STATUS_TOO_FEW;
      end else begin
        mean_q   <= quotient;
        status_q <= ovf_q ? STATUS_TOO_MANY : STATUS_OK;
      end
    end
  end

  stm_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (acc_q),
    .divisor_i  (count_q[CntW-1:1]),
    .busy_o     (div_busy),
    .quotient_o (quotient)
  );

  always_comb begin
    stat_o          = '0;
    stat_o.full     = count_q == CntW'(MaxSamples);
    stat_o.few      = few;
    stat_o.pos_zero = pos_q == '0;
    stat_o.pos_one  = pos_q == AddrW'(1);
    stat_o.less     = val_q < rdata_q;
    stat_o.last     = last_q;
    stat_o.sum_done = left_q == '0;
    stat_o.div_busy = div_busy;
    stat_o.out_busy = out_valid_q && !out_ready_i;
  end

  assign out_valid_o = out_valid_q;
  assign mean_o      = mean_q;
  assign status_o    = status_q;

endmodule

[hw/rtl/stm_ctrl.sv]
// Controller: insertion, summing, division and output sequencing.
// Depends on stm_pkg; commands the stm_datapath.
module stm_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  stm_pkg::stm_stat_t stat_i,
  output stm_pkg::stm_cmd_t  cmd_o
);
  import stm_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_PROBE = 7'b0000010,
    S_CMP   = 7'b0000100,
    S_CHECK = 7'b0001000,
    S_SUM   = 7'b0010000,
    S_DIV   = 7'b0100000,
    S_EMIT  = 7'b1000000
  } state_e;

  state_e state_q, state_d;
  state_e after_ins;

  // Where to go once the sample is placed or dropped
  assign after_ins = stat_i.last ? S_CHECK : S_IDLE;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = S_PROBE;
        end
      end
      S_PROBE: begin
        if (stat_i.full) begin
          cmd_o.set_ovf = 1'b1;
          state_d       = after_ins;
        end else if (stat_i.pos_zero) begin
          cmd_o.write_val = 1'b1;
          state_d         = after_ins;
        end else begin
          state_d = S_CMP;
        end
      end
      S_CMP: begin
        if (stat_i.less) begin
          cmd_o.shift = 1'b1;
          // slot zero is written without a compare
          state_d     = stat_i.pos_one ? S_PROBE : S_CMP;
        end else begin
          cmd_o.write_val = 1'b1;
          state_d         = after_ins;
        end
      end
      S_CHECK: begin
        if (stat_i.few) begin
          state_d = S_EMIT;
        end else begin
          cmd_o.sum_init = 1'b1;
          state_d        = S_SUM;
        end
      end
      S_SUM: begin
        if (stat_i.sum_done) begin
          cmd_o.div_start = 1'b1;
          state_d         = S_DIV;
        end else begin
          cmd_o.sum_acc = 1'b1;
        end
      end
      S_DIV: begin
        if (!stat_i.div_busy) state_d = S_EMIT;
      end
      S_EMIT: begin
        if (!stat_i.out_busy) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

[hw/rtl/sorted_trimmed_mean.sv]
// Top level of the sorted trimmed mean block: controller plus datapath.
// Depends on stm_pkg, stm_ctrl, stm_datapath (which holds stm_div).
//
//   channel   direction  tdata                               tlast
//   s_axis    in         [15:0] sample                       last
//   m_axis    out        [15:0] mean, [17:16] status, pad    -
//
// A sample into an empty or full store is written or dropped without a compare;
// else it moves each larger stored entry up one slot (up to 7) before it is written.
// A marked sample then has n/2 entries summed from the memory read port and the
// sum divided by n/2 in the bit-serial divider (19 quotient bits), then the
// output word is loaded; a run of fewer than two samples skips summing and
// division.
// The output word is registered, so input keeps flowing while a result waits;
// only a marked sample stalls until the previous result is taken.
// Reset clears the count, the drop flag, the sum counter, the divider step, the state and the output valid.
module sorted_trimmed_mean (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [stm_pkg::SampleW-1:0]   s_axis_tdata,   // [15:0] sample
  input  logic                          s_axis_tlast,   // last
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [stm_pkg::OutDataW-1:0]  m_axis_tdata    // [15:0] mean, [17:16] status
);
  import stm_pkg::*;

  stm_cmd_t            cmd;
  stm_stat_t           stat;
  logic [SampleW-1:0]  mean;
  logic [StatusW-1:0]  status;

  stm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  stm_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .sample_i    (s_axis_tdata),
    .last_i      (s_axis_tlast),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .mean_o      (mean),
    .status_o    (status)
  );

  assign m_axis_tdata = {(OutDataW - SampleW - StatusW)'(0), status, mean};

endmodule
